### design/greek_to_latin_transliterator_macros.svh
// assertion helpers used by the top-level module
`ifndef GREEK_TO_LATIN_TRANSLITERATOR_MACROS_SVH
`define GREEK_TO_LATIN_TRANSLITERATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define G2L_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define G2L_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/g2l_pkg.sv
`timescale 1ns / 1ps

package g2l_pkg;

	// byte codes of the letters that combine, and the table and ascii bounds
	localparam logic [7:0] CODE_NU      = 8'd237;
	localparam logic [7:0] CODE_NU_CAP  = 8'd205;
	localparam logic [7:0] CODE_MU      = 8'd236;
	localparam logic [7:0] CODE_MU_CAP  = 8'd204;
	localparam logic [7:0] CODE_TAU     = 8'd244;
	localparam logic [7:0] CODE_TAU_CAP = 8'd212;
	localparam logic [7:0] CODE_PI      = 8'd240;
	localparam logic [7:0] CODE_PI_CAP  = 8'd208;
	localparam logic [7:0] ROM_BASE     = 8'd160;
	localparam logic [7:0] ASCII_TOP    = 8'd126;

	// ascii codes emitted for held and combined letters
	localparam logic [6:0] CHAR_N_LOW = 7'h6E;
	localparam logic [6:0] CHAR_N_CAP = 7'h4E;
	localparam logic [6:0] CHAR_M_LOW = 7'h6D;
	localparam logic [6:0] CHAR_M_CAP = 7'h4D;
	localparam logic [6:0] CHAR_D_LOW = 7'h64;
	localparam logic [6:0] CHAR_D_CAP = 7'h44;
	localparam logic [6:0] CHAR_B_LOW = 7'h62;
	localparam logic [6:0] CHAR_B_CAP = 7'h42;

	// result slots per transaction, and queue sizing
	localparam int JOB_SLOTS   = 5;
	localparam int SLOT_W      = $clog2(JOB_SLOTS + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		HELD_NONE,
		HELD_NU,
		HELD_NU_CAP,
		HELD_MU,
		HELD_MU_CAP
	} held_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       unrecognized;
		logic       last_of_run;
	} out_item_t;

	// all results of one input transaction
	typedef struct packed {
		logic [JOB_SLOTS-1:0][6:0] chars;
		logic [JOB_SLOTS-1:0]      unrec;
		logic [SLOT_W-1:0]         cnt;
	} job_t;

	typedef struct packed {
		logic [1:0]      len;
		logic [2:0][6:0] chars;
	} rom_entry_t;

	function automatic held_t hold_code(input logic [7:0] b);
		held_t h;
		h = HELD_NONE;
		if (b == CODE_NU) h = HELD_NU;
		else if (b == CODE_NU_CAP) h = HELD_NU_CAP;
		else if (b == CODE_MU) h = HELD_MU;
		else if (b == CODE_MU_CAP) h = HELD_MU_CAP;
		return h;
	endfunction

	function automatic logic [6:0] held_char(input held_t h);
		logic [6:0] c;
		case (h)
			HELD_NU:     c = CHAR_N_LOW;
			HELD_NU_CAP: c = CHAR_N_CAP;
			HELD_MU:     c = CHAR_M_LOW;
			HELD_MU_CAP: c = CHAR_M_CAP;
			default:     c = 7'h00;
		endcase
		return c;
	endfunction

	// expansion table for bytes 160..255, strings right-justified in three bytes
	function automatic rom_entry_t xlat_rom(input logic [6:0] idx);
		logic [23:0] w;
		rom_entry_t  e;
		e = '0;
		case (idx)
			7'd0:  w = 24'(" ");
			7'd1:  w = 24'("'");
			7'd2:  w = 24'("'");
			7'd3:  w = 24'("$");
			7'd4:  w = 24'h0;
			7'd5:  w = 24'h0;
			7'd6:  w = 24'("|");
			7'd7:  w = 24'("*p");
			7'd8:  w = 24'("\"");
			7'd9:  w = 24'("*c");
			7'd10: w = 24'h0;
			7'd11: w = 24'("<<");
			7'd12: w = 24'("*n");
			7'd13: w = 24'(" ");
			7'd14: w = 24'h0;
			7'd15: w = 24'("-");
			7'd16: w = 24'("*d");
			7'd17: w = 24'("+-");
			7'd18: w = 24'("^2");
			7'd19: w = 24'("^3");
			7'd20: w = 24'("'");
			7'd21: w = 24'("'\"");
			7'd22: w = 24'("A'");
			7'd23: w = 24'(".");
			7'd24: w = 24'("E'");
			7'd25: w = 24'("H'");
			7'd26: w = 24'("I'");
			7'd27: w = 24'(">>");
			7'd28: w = 24'("O'");
			7'd29: w = 24'("*h");
			7'd30: w = 24'("Y'");
			7'd31: w = 24'("W'");
			7'd32: w = 24'("i'\"");
			7'd33: w = 24'("A");
			7'd34: w = 24'("V");
			7'd35: w = 24'("G");
			7'd36: w = 24'("D");
			7'd37: w = 24'("E");
			7'd38: w = 24'("Z");
			7'd39: w = 24'("H");
			7'd40: w = 24'("8");
			7'd41: w = 24'("I");
			7'd42: w = 24'("K");
			7'd43: w = 24'("L");
			7'd44: w = 24'("M");
			7'd45: w = 24'("N");
			7'd46: w = 24'("KS");
			7'd47: w = 24'("O");
			7'd48: w = 24'("P");
			7'd49: w = 24'("R");
			7'd50: w = 24'h0;
			7'd51: w = 24'("S");
			7'd52: w = 24'("T");
			7'd53: w = 24'("Y");
			7'd54: w = 24'("F");
			7'd55: w = 24'("X");
			7'd56: w = 24'("PS");
			7'd57: w = 24'("W");
			7'd58: w = 24'("I\"");
			7'd59: w = 24'("Y\"");
			7'd60: w = 24'("a'");
			7'd61: w = 24'("e'");
			7'd62: w = 24'("h'");
			7'd63: w = 24'("i'");
			7'd64: w = 24'("y'\"");
			7'd65: w = 24'("a");
			7'd66: w = 24'("v");
			7'd67: w = 24'("g");
			7'd68: w = 24'("d");
			7'd69: w = 24'("e");
			7'd70: w = 24'("z");
			7'd71: w = 24'("h");
			7'd72: w = 24'("8");
			7'd73: w = 24'("i");
			7'd74: w = 24'("k");
			7'd75: w = 24'("l");
			7'd76: w = 24'("m");
			7'd77: w = 24'("n");
			7'd78: w = 24'("ks");
			7'd79: w = 24'("o");
			7'd80: w = 24'("p");
			7'd81: w = 24'("r");
			7'd82: w = 24'("s");
			7'd83: w = 24'("s");
			7'd84: w = 24'("t");
			7'd85: w = 24'("y");
			7'd86: w = 24'("f");
			7'd87: w = 24'("x");
			7'd88: w = 24'("ps");
			7'd89: w = 24'("w");
			7'd90: w = 24'("i\"");
			7'd91: w = 24'("y\"");
			7'd92: w = 24'("o'");
			7'd93: w = 24'("y'");
			7'd94: w = 24'("w'");
			7'd95: w = 24'h0;
			default: w = 24'h0;
		endcase
		// unpack into first-to-last order
		if (w[23:16] != 8'h00) begin
			e.len      = 2'd3;
			e.chars[0] = w[22:16];
			e.chars[1] = w[14:8];
			e.chars[2] = w[6:0];
		end else if (w[15:8] != 8'h00) begin
			e.len      = 2'd2;
			e.chars[0] = w[14:8];
			e.chars[1] = w[6:0];
		end else if (w[7:0] != 8'h00) begin
			e.len      = 2'd1;
			e.chars[0] = w[6:0];
		end
		return e;
	endfunction

endpackage

### design/g2l_front.sv
`timescale 1ns / 1ps

module g2l_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  g2l_pkg::in_item_t item,
	input  logic              q_full,
	output logic              q_push,
	output g2l_pkg::job_t     q_job
);

	g2l_pkg::held_t      held_q;
	g2l_pkg::held_t      held_d;
	g2l_pkg::held_t      hold_new;
	g2l_pkg::rom_entry_t rom;
	g2l_pkg::job_t       job;
	logic [g2l_pkg::SLOT_W-1:0] n;
	logic [7:0]          b;
	logic [6:0]          rom_idx;
	logic                accept;

	assign b          = item.in_byte;
	assign rom_idx    = 7'(b - g2l_pkg::ROM_BASE);
	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;

	// classify the byte and list every result it causes
	always_comb begin
		job      = '0;
		n        = '0;
		held_d   = held_q;
		hold_new = g2l_pkg::hold_code(b);
		rom      = g2l_pkg::xlat_rom(rom_idx);
		if (hold_new != g2l_pkg::HELD_NONE) begin
			if (held_q != g2l_pkg::HELD_NONE) begin
				job.chars[n] = g2l_pkg::held_char(held_q);
				n = n + 1'b1;
			end
			held_d = hold_new;
		end else if ((held_q == g2l_pkg::HELD_NU || held_q == g2l_pkg::HELD_NU_CAP) &&
				(b == g2l_pkg::CODE_TAU || b == g2l_pkg::CODE_TAU_CAP)) begin
			job.chars[n] = (held_q == g2l_pkg::HELD_NU) ? g2l_pkg::CHAR_D_LOW
				: g2l_pkg::CHAR_D_CAP;
			n = n + 1'b1;
			held_d = g2l_pkg::HELD_NONE;
		end else if ((held_q == g2l_pkg::HELD_MU || held_q == g2l_pkg::HELD_MU_CAP) &&
				(b == g2l_pkg::CODE_PI || b == g2l_pkg::CODE_PI_CAP)) begin
			job.chars[n] = (held_q == g2l_pkg::HELD_MU) ? g2l_pkg::CHAR_B_LOW
				: g2l_pkg::CHAR_B_CAP;
			n = n + 1'b1;
			held_d = g2l_pkg::HELD_NONE;
		end else begin
			// release the held letter, then translate
			if (held_q != g2l_pkg::HELD_NONE) begin
				job.chars[n] = g2l_pkg::held_char(held_q);
				n = n + 1'b1;
			end
			held_d = g2l_pkg::HELD_NONE;
			if (b <= g2l_pkg::ASCII_TOP) begin
				job.chars[n] = b[6:0];
				n = n + 1'b1;
			end else if (b >= g2l_pkg::ROM_BASE) begin
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < rom.len) begin
						job.chars[n] = rom.chars[i];
						n = n + 1'b1;
					end
				end
			end else begin
				job.chars[n] = 7'h00;
				job.unrec[n] = 1'b1;
				n = n + 1'b1;
			end
		end
		// end of text flushes a letter still held
		if (item.end_of_text && held_d != g2l_pkg::HELD_NONE) begin
			job.chars[n] = g2l_pkg::held_char(held_d);
			n = n + 1'b1;
			held_d = g2l_pkg::HELD_NONE;
		end
		job.cnt = n;
	end

	assign q_job  = job;
	assign q_push = accept && (n != '0);

	// held letter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= g2l_pkg::HELD_NONE;
		end else if (accept) begin
			held_q <= held_d;
		end
	end

endmodule

### design/g2l_queue.sv
`timescale 1ns / 1ps

module g2l_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  g2l_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          pop_valid,
	output g2l_pkg::job_t pop_job
);

	g2l_pkg::job_t                 slot_q [g2l_pkg::QUEUE_DEPTH];
	logic [g2l_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [g2l_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [g2l_pkg::QCNT_W-1:0]    count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full      = (count_q == g2l_pkg::QCNT_W'(g2l_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_job   = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	// job storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_job;
	end

endmodule

### design/g2l_back.sv
`timescale 1ns / 1ps

module g2l_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  g2l_pkg::job_t      q_job,
	output logic               q_pop,
	output logic               result_valid,
	input  logic               result_stall,
	output g2l_pkg::out_item_t result
);

	g2l_pkg::job_t              job_q;
	logic                       job_valid_q;
	logic [g2l_pkg::SLOT_W-1:0] idx_q;
	logic                       result_valid_q;
	g2l_pkg::out_item_t         result_q;
	logic                       out_free;
	logic                       emit;
	logic                       at_last;
	logic                       job_free;

	assign out_free = !result_valid_q || !result_stall;
	assign at_last  = (idx_q == job_q.cnt - 1'b1);
	assign emit     = job_valid_q && out_free;
	assign job_free = !job_valid_q || (emit && at_last);
	assign q_pop    = q_valid && job_free;

	// current job and slot index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (q_pop) begin
			job_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (emit && at_last) begin
			job_valid_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) job_q <= q_job;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.out_char     <= job_q.chars[idx_q];
			result_q.unrecognized <= job_q.unrec[idx_q];
			result_q.last_of_run  <= at_last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### design/greek_to_latin_transliterator.sv
`timescale 1ns / 1ps
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+-----------------------------------
// input    | item_valid   | item_stall   | item   (in_byte, end_of_text)
// output   | result_valid | result_stall | result (out_char, unrecognized,
//          |              |              |         last_of_run)
// One input transaction is taken per cycle while the job queue has room.
// Results leave the output register one at a time, so an item with k
// results (k is 0 to 4) holds the output until all k are sent; a four-job
// queue absorbs expansions. A result passes a queue slot, the job register and the output register.
// Reset clears the held letter, empties the queue and drops result_valid.
// item_stall rises only when the queue is full; result_stall freezes the
// output register while the front keeps filling the queue.

`include "greek_to_latin_transliterator_macros.svh"

module greek_to_latin_transliterator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  g2l_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output g2l_pkg::out_item_t result
);

	logic          q_full;
	logic          q_push;
	logic          q_pop;
	logic          q_valid;
	g2l_pkg::job_t push_job;
	g2l_pkg::job_t q_job;

	// classify and expand
	g2l_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	// job queue between front and back
	g2l_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_job   (q_job)
	);

	// serialize results
	g2l_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_job        (q_job),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// queued jobs always carry one to five results
	`G2L_ASSERT_IMP(a_job_count, q_valid, q_job.cnt != '0 && q_job.cnt <= 3'd5, "bad job count")

	// an unrecognized result carries no character
	`G2L_ASSERT_IMP(a_unrec_char, result_valid && result.unrecognized, result.out_char == 7'h00, "unrecognized result with character")

	// results of one transaction follow each other without gaps
	`G2L_ASSERT_NEXT(a_run_gapless, result_valid && !result_stall && !result.last_of_run, result_valid, "gap inside a run")

endmodule
